>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AST_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define AST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define AST_CHECK(lbl, prop, msg)

`define AST_NEVER(lbl, cond, msg)

`endif

`endif

>>> hw/rtl/fbpa_pkg.sv
// Types, constants and codes for the fixed block pool allocator.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int INDEX_REACH = 64;
  localparam int POOL_LIMIT  = (MAX_BLOCKS < INDEX_REACH) ? MAX_BLOCKS : INDEX_REACH;
  localparam int STK_AW      = $clog2(POOL_LIMIT);
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int BC_W        = 7;
  localparam int CFG_AW      = 3;

  localparam logic [BC_W-1:0]   BLOCK_COUNT_RST      = 7'd64;
  localparam logic [CFG_AW-1:0] CFG_ADDR_BLOCK_COUNT = 3'd0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_DOUBLE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK
  } state_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_index;
  } out_item_t;

endpackage

>>> hw/rtl/fbpa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies; instanced by the allocator top level.
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/fixed_block_pool_allocator_unit.sv
// Top level of the fixed block pool allocator: control, registers and APB port.
// Depends on fbpa_pkg, fbpa_ram and assert_macros.svh.
//
// Usage: the in_ channel carries one request item (allocate, or free a block index)
// and the out_ channel returns exactly one result item per request, in order.
// Both channels use valid/ready. block_count is written over the APB-style port at
// byte address 0 and read back there; pready is always high.
// An item is accepted only while the control is idle. On acceptance the freed-stack
// RAM and the position RAM are read; their registered data is used in the next cycle.
// An allocate, or a free that fails the high-water check, finishes in S_LOOK once
// the out_ slot is free: its result is registered and the control returns to idle.
// A free that passes the high-water check reads the stack entry at its recorded
// position for the membership check in S_CHECK, which then finishes the same way.
// The result register parts the two sides: a new item is accepted while an earlier
// result still waits, and only the commit of the following result waits for the
// out_ slot, with all state changes held until it commits.
// Reset clears the high-water mark, the stack depth and the position valid bits,
// and sets block_count to 64; no clearing pass is needed.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fixed_block_pool_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fbpa_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fbpa_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbpa_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  fbpa_pkg::state_t                  state_r, state_nxt;
  fbpa_pkg::opcode_t                 op_r;
  logic [fbpa_pkg::IDX_W-1:0]        idx_r;
  logic [fbpa_pkg::BC_W-1:0]         block_count_r;
  logic [fbpa_pkg::CNT_W-1:0]        high_water_r, high_water_nxt;
  logic [fbpa_pkg::CNT_W-1:0]        free_depth_r, free_depth_nxt;
  logic [fbpa_pkg::INDEX_REACH-1:0]  pos_vld_r;
  logic                              out_valid_r, out_valid_nxt;
  fbpa_pkg::out_item_t               out_data_r, out_data_nxt;

  logic                              stk_we, stk_re;
  logic [fbpa_pkg::STK_AW-1:0]       stk_waddr, stk_raddr;
  logic [fbpa_pkg::IDX_W-1:0]        stk_wdata, stk_rdata;
  logic                              pos_we, pos_re;
  logic [fbpa_pkg::IDX_W-1:0]        pos_waddr, pos_raddr;
  logic [fbpa_pkg::STK_AW-1:0]       pos_wdata, pos_rdata;
  logic                              vld_set;

  logic                              accept, slot_free, hit, cfg_wr;
  logic [fbpa_pkg::CNT_W-1:0]        pool_size, idx_ext, pos_ext, depth_m1, hw_m1;
  fbpa_pkg::out_item_t               res;
  logic                              grant_leak;

  fbpa_ram #(
    .WIDTH (fbpa_pkg::IDX_W),
    .DEPTH (fbpa_pkg::POOL_LIMIT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  fbpa_ram #(
    .WIDTH (fbpa_pkg::STK_AW),
    .DEPTH (fbpa_pkg::INDEX_REACH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign in_ready  = (state_r == fbpa_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  assign pool_size = (block_count_r > fbpa_pkg::CNT_W'(fbpa_pkg::POOL_LIMIT)) ?
                     fbpa_pkg::CNT_W'(fbpa_pkg::POOL_LIMIT) : block_count_r;
  assign idx_ext   = fbpa_pkg::CNT_W'(idx_r);
  assign pos_ext   = fbpa_pkg::CNT_W'(pos_rdata);
  assign depth_m1  = free_depth_r - 1'b1;
  assign hw_m1     = high_water_r - 1'b1;
  assign hit       = pos_vld_r[idx_r] && (pos_ext < free_depth_r) && (stk_rdata == idx_r);

  assign grant_leak = out_valid_r && (out_data_r.status != fbpa_pkg::ST_OK) &&
                      (out_data_r.granted_index != '0);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == fbpa_pkg::CFG_ADDR_BLOCK_COUNT);
  assign prdata = (paddr == fbpa_pkg::CFG_ADDR_BLOCK_COUNT) ?
                  {{(32 - fbpa_pkg::BC_W){1'b0}}, block_count_r} : 32'd0;

  always_comb begin
    state_nxt      = state_r;
    high_water_nxt = high_water_r;
    free_depth_nxt = free_depth_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    stk_re         = 1'b0;
    stk_raddr      = depth_m1[fbpa_pkg::STK_AW-1:0];
    stk_we         = 1'b0;
    stk_waddr      = free_depth_r[fbpa_pkg::STK_AW-1:0];
    stk_wdata      = idx_r;
    pos_re         = 1'b0;
    pos_raddr      = in_data.block_index;
    pos_we         = 1'b0;
    pos_waddr      = idx_r;
    pos_wdata      = free_depth_r[fbpa_pkg::STK_AW-1:0];
    vld_set        = 1'b0;
    res.status        = fbpa_pkg::ST_OK;
    res.granted_index = '0;
    unique case (state_r)
      fbpa_pkg::S_IDLE: begin
        if (in_valid) begin
          stk_re    = 1'b1;
          pos_re    = 1'b1;
          state_nxt = fbpa_pkg::S_LOOK;
        end
      end
      fbpa_pkg::S_LOOK: begin
        if (op_r == fbpa_pkg::OP_ALLOC) begin
          if (free_depth_r != '0) begin
            res.granted_index = stk_rdata;
          end else if (high_water_r < pool_size) begin
            res.granted_index = high_water_r[fbpa_pkg::IDX_W-1:0];
          end else begin
            res.status = fbpa_pkg::ST_FULL;
          end
          if (slot_free) begin
            if (free_depth_r != '0) begin
              free_depth_nxt = depth_m1;
            end else if (high_water_r < pool_size) begin
              high_water_nxt = high_water_r + 1'b1;
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
            state_nxt     = fbpa_pkg::S_IDLE;
          end
        end else if ((high_water_r == '0) || (idx_ext >= high_water_r)) begin
          res.status = fbpa_pkg::ST_INVALID;
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
            state_nxt     = fbpa_pkg::S_IDLE;
          end
        end else begin
          stk_re    = 1'b1;
          stk_raddr = pos_rdata;
          state_nxt = fbpa_pkg::S_CHECK;
        end
      end
      fbpa_pkg::S_CHECK: begin
        if (hit) begin
          res.status = fbpa_pkg::ST_DOUBLE;
        end
        if (slot_free) begin
          if (!hit) begin
            if (idx_ext == hw_m1) begin
              high_water_nxt = hw_m1;
            end else if (free_depth_r < fbpa_pkg::CNT_W'(fbpa_pkg::POOL_LIMIT)) begin
              stk_we         = 1'b1;
              pos_we         = 1'b1;
              vld_set        = 1'b1;
              free_depth_nxt = free_depth_r + 1'b1;
            end
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          state_nxt     = fbpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fbpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= fbpa_pkg::S_IDLE;
      high_water_r  <= '0;
      free_depth_r  <= '0;
      pos_vld_r     <= '0;
      out_valid_r   <= 1'b0;
      block_count_r <= fbpa_pkg::BLOCK_COUNT_RST;
    end else begin
      state_r      <= state_nxt;
      high_water_r <= high_water_nxt;
      free_depth_r <= free_depth_nxt;
      out_valid_r  <= out_valid_nxt;
      if (vld_set) begin
        pos_vld_r[idx_r] <= 1'b1;
      end
      if (cfg_wr) begin
        block_count_r <= pwdata[fbpa_pkg::BC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      op_r  <= in_data.opcode;
      idx_r <= in_data.block_index;
    end
  end

  `AST_CHECK(a_depth_le_hw, free_depth_r <= high_water_r, "Stack deeper than high-water mark.")
  `AST_CHECK(a_hw_le_limit, high_water_r <= 7'd64, "High-water mark beyond pool reach.")
  `AST_CHECK(a_one_item, (in_valid && in_ready) |=> !in_ready, "Second item taken while busy.")
  `AST_NEVER(a_grant_ok, grant_leak, "Nonzero grant on a failed request.")

endmodule

>>> tb/tb_fixed_block_pool_allocator_unit.sv
// Self-checking testbench for fixed_block_pool_allocator_unit.
// A free-list predictor checks every allocate/free result; needs fbpa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_unit;

  localparam int PLAN = 0;
  localparam int CHECK = 1;
  localparam int LONG_STALL = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [fbpa_pkg::CFG_AW-1:0] CFG_ADDR_UNUSED = 3'd4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fbpa_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fbpa_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fbpa_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [fbpa_pkg::BC_W-1:0] pool_count [2];
  logic [fbpa_pkg::CNT_W-1:0] pool_hw [2];
  logic [fbpa_pkg::CNT_W-1:0] freed_depth [2];
  logic [fbpa_pkg::IDX_W-1:0] freed_stack [2][fbpa_pkg::MAX_BLOCKS];

  fbpa_pkg::in_item_t request_q [$];
  fbpa_pkg::out_item_t predicted_q [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalls_asked = 0;
  int stalls_served = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  int phase_count [12] = '{64, 64, 20, 1, 127, 64, 33, 64, 0, 64, 9, 64};
  int phase_alloc [12] = '{50, 90, 30, 70, 50, 90, 20, 60, 50, 85, 40, 60};

  fixed_block_pool_allocator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic bit on_freed(int m, logic [fbpa_pkg::IDX_W-1:0] idx);
    for (int i = 0; i < freed_depth[m]; i++) begin
      if (freed_stack[m][i] == idx) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic fbpa_pkg::out_item_t pool_step(int m, fbpa_pkg::in_item_t req);
    fbpa_pkg::out_item_t res;
    int limit;
    res.status = fbpa_pkg::ST_OK;
    res.granted_index = '0;
    limit = (pool_count[m] > fbpa_pkg::POOL_LIMIT) ? fbpa_pkg::POOL_LIMIT : pool_count[m];
    if (req.opcode == fbpa_pkg::OP_ALLOC) begin
      if (freed_depth[m] > 0) begin
        freed_depth[m] = freed_depth[m] - 1'b1;
        res.granted_index = freed_stack[m][freed_depth[m]];
      end else if (pool_hw[m] < limit) begin
        res.granted_index = pool_hw[m][fbpa_pkg::IDX_W-1:0];
        pool_hw[m] = pool_hw[m] + 1'b1;
      end else begin
        res.status = fbpa_pkg::ST_FULL;
      end
    end else begin
      if (pool_hw[m] == 0 || req.block_index >= pool_hw[m]) begin
        res.status = fbpa_pkg::ST_INVALID;
      end else if (on_freed(m, req.block_index)) begin
        res.status = fbpa_pkg::ST_DOUBLE;
      end else if (req.block_index == pool_hw[m] - 1'b1) begin
        pool_hw[m] = pool_hw[m] - 1'b1;
      end else if (freed_depth[m] < fbpa_pkg::MAX_BLOCKS) begin
        freed_stack[m][freed_depth[m]] = req.block_index;
        freed_depth[m] = freed_depth[m] + 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endfunction

  function automatic logic [fbpa_pkg::IDX_W-1:0] pick_live();
    int k;
    k = $urandom_range(0, pool_hw[PLAN] - freed_depth[PLAN] - 1);
    for (int i = 0; i < pool_hw[PLAN]; i++) begin
      if (!on_freed(PLAN, fbpa_pkg::IDX_W'(i))) begin
        if (k == 0) return fbpa_pkg::IDX_W'(i);
        k--;
      end
    end
    return '0;
  endfunction

  task automatic queue_request(fbpa_pkg::opcode_t op, logic [fbpa_pkg::IDX_W-1:0] idx);
    fbpa_pkg::in_item_t req;
    fbpa_pkg::out_item_t ignored;
    req.opcode = op;
    req.block_index = idx;
    request_q.push_back(req);
    ignored = pool_step(PLAN, req);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || predicted_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_access(logic [fbpa_pkg::CFG_AW-1:0] addr, logic [31:0] data, logic wr,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rdata = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_block_count(int value);
    logic [31:0] rdata;
    logic [31:0] wdata;
    wait_drained();
    wdata = ($urandom() & 32'hFFFF_FF80) | (value & 32'h7F);
    cfg_access(fbpa_pkg::CFG_ADDR_BLOCK_COUNT, wdata, 1'b1, rdata);
    pool_count[PLAN] = wdata[fbpa_pkg::BC_W-1:0];
    pool_count[CHECK] = wdata[fbpa_pkg::BC_W-1:0];
    cfg_access(fbpa_pkg::CFG_ADDR_BLOCK_COUNT, '0, 1'b0, rdata);
    if (rdata !== {25'b0, wdata[fbpa_pkg::BC_W-1:0]})
      note_failure($sformatf("block_count read %0h, want %0h", rdata,
                             wdata[fbpa_pkg::BC_W-1:0]));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stalls_served != stalls_asked) begin
      stalls_served++;
      stall_left = LONG_STALL;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    fbpa_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          note_failure($sformatf("unexpected result status %0d index %0d",
                                 out_data.status, out_data.granted_index));
        end else begin
          want = predicted_q.pop_front();
          if (out_data.status !== want.status || out_data.granted_index !== want.granted_index)
            note_failure($sformatf("status %0d index %0d, want status %0d index %0d",
                                   out_data.status, out_data.granted_index,
                                   want.status, want.granted_index));
        end
      end
      if (in_valid && in_ready) predicted_q.push_back(pool_step(CHECK, in_data));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (request_q.size() != 0 || in_valid || predicted_q.size() != 0) begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [31:0] rdata;
    int r;
    logic [fbpa_pkg::IDX_W-1:0] idx;
    fbpa_pkg::opcode_t op;
    for (int m = 0; m < 2; m++) begin
      pool_count[m] = fbpa_pkg::BLOCK_COUNT_RST;
      pool_hw[m] = '0;
      freed_depth[m] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 76;

    cfg_access(fbpa_pkg::CFG_ADDR_BLOCK_COUNT, '0, 1'b0, rdata);
    if (rdata !== {25'b0, fbpa_pkg::BLOCK_COUNT_RST})
      note_failure($sformatf("block_count after reset %0h", rdata));

    set_block_count(2);
    queue_request(fbpa_pkg::OP_FREE, 6'd0);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd63);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd0);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd21);
    queue_request(fbpa_pkg::OP_FREE, 6'd63);
    queue_request(fbpa_pkg::OP_FREE, 6'd0);
    queue_request(fbpa_pkg::OP_FREE, 6'd0);
    queue_request(fbpa_pkg::OP_FREE, 6'd1);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd42);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd0);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd63);
    queue_request(fbpa_pkg::OP_FREE, 6'd1);
    queue_request(fbpa_pkg::OP_FREE, 6'd0);
    queue_request(fbpa_pkg::OP_FREE, 6'd0);

    set_block_count(0);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd0);
    queue_request(fbpa_pkg::OP_FREE, 6'd0);

    set_block_count(127);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd0);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd0);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd0);
    set_block_count(1);
    wait_drained();
    cfg_access(CFG_ADDR_UNUSED, 32'h0000_0005, 1'b1, rdata);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd0);
    queue_request(fbpa_pkg::OP_FREE, 6'd2);
    queue_request(fbpa_pkg::OP_FREE, 6'd0);
    queue_request(fbpa_pkg::OP_ALLOC, 6'd0);
    queue_request(fbpa_pkg::OP_FREE, 6'd1);
    queue_request(fbpa_pkg::OP_FREE, 6'd0);

    for (int ph = 0; ph < 12; ph++) begin
      set_block_count(phase_count[ph]);
      @(negedge clk);
      send_idle_pct = (ph < 4) ? 14 : (ph < 8) ? 76 : 0;
      recv_idle_pct = (ph < 4) ? 76 : (ph < 8) ? 14 : 0;
      if (ph == 5 || ph == 9) stalls_asked++;
      for (int n = 0; n < 85; n++) begin
        op = ($urandom_range(0, 99) < phase_alloc[ph]) ? fbpa_pkg::OP_ALLOC : fbpa_pkg::OP_FREE;
        idx = fbpa_pkg::IDX_W'($urandom_range(0, 63));
        if (op == fbpa_pkg::OP_FREE) begin
          r = $urandom_range(0, 99);
          if (r < 65 && pool_hw[PLAN] > freed_depth[PLAN])
            idx = pick_live();
          else if (r < 75 && freed_depth[PLAN] > 0)
            idx = freed_stack[PLAN][$urandom_range(0, freed_depth[PLAN] - 1)];
        end
        queue_request(op, idx);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (predicted_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", predicted_q.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
